>>> sv/psps_pkg.sv
package psps_pkg;

   // Field widths
   localparam int FRAC_W    = 16;
   localparam int DIR_W     = 16;
   localparam int POS_W     = 32;
   localparam int GROUP_W   = 3;
   localparam int PROB_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam int REQ_DAT_W = 48;
   localparam int RSP_DAT_W = 152;

   // Defaults for the top-level parameters
   localparam int MAX_GROUPS_DEF   = 4;
   localparam int CORDIC_STEPS_DEF = 16;

   // Fixed sizes of the datapath
   localparam int PROB_REGS  = 4;
   localparam int SQRT_STEPS = 16;
   localparam int ATAN_IDX_W = 5;
   localparam int CORDIC_W   = 32;

   // Q2.30 inverse CORDIC gain, start value of x
   localparam logic [CORDIC_W-1:0] CORDIC_GAIN_INV = 32'd652032874;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_GROUP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROB_0      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PROB_1      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PROB_2      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PROB_3      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_X    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_Y    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_Z    = 3'd7;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [CORDIC_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
      logic [CORDIC_W-1:0] val;
      case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> sv/point_source_particle_sampler.sv
// Flow: the request is loaded, run through the shared step loop of N = max(16, CORDIC_STEPS,
// MAX_GROUPS) steps, then through the cosine and sine products, and finished into the output.
// A new request is taken only once the previous one has reached the output register; the
// step loop (root digit, CORDIC rotation, group sum) and the shared product multiplier set the pace.
// A finished response waits in the output register while the next request is taken.
// Reset: synchronous, active high; clears control state and loads the register defaults.
module point_source_particle_sampler #(
   parameter int MAX_GROUPS   = psps_pkg::MAX_GROUPS_DEF,
   parameter int CORDIC_STEPS = psps_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // fields from bit 0 up: group_rand[15:0], mu_rand[15:0], phi_rand[15:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [psps_pkg::REQ_DAT_W-1:0]      req_tdata,
   // fields from bit 0 up: pos_x[31:0], pos_y[31:0], pos_z[31:0], dir_x[15:0],
   // dir_y[15:0], dir_z[15:0], energy_group[2:0], zero pad to 152 bits
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [psps_pkg::RSP_DAT_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [psps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psps_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   // The step loop runs until the slowest of its three units is done
   localparam int ITER_A = (psps_pkg::SQRT_STEPS > CORDIC_STEPS) ?
                           psps_pkg::SQRT_STEPS : CORDIC_STEPS;
   localparam int N_ITER = (ITER_A > MAX_GROUPS) ? ITER_A : MAX_GROUPS;
   localparam int CNT_W  = $clog2(N_ITER);
   localparam int GN_W   = $clog2(MAX_GROUPS + 1);
   localparam int SUM_W  = psps_pkg::PROB_W + $clog2(MAX_GROUPS);
   localparam int CW     = psps_pkg::CORDIC_W;
   localparam int PROD_W = psps_pkg::DIR_W + CW + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ITER,
      ST_MUL_C,
      ST_MUL_S,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic [psps_pkg::GROUP_W-1:0] gcount_ff;
   logic [psps_pkg::PROB_W-1:0]  prob_ff [psps_pkg::PROB_REGS];
   logic [psps_pkg::POS_W-1:0]   src_x_ff, src_y_ff, src_z_ff;

   // Working registers
   logic [psps_pkg::FRAC_W-1:0]  gfrac_ff;
   logic [psps_pkg::FRAC_W-1:0]  phi_ff;
   logic signed [psps_pkg::DIR_W-1:0] mu_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [CW-1:0]                rem_ff, root_ff;
   logic signed [CW-1:0]         x_ff, y_ff, z_ff;
   logic [1:0]                   quad_ff;
   logic [SUM_W-1:0]             sum_ff;
   logic [psps_pkg::GROUP_W-1:0] grp_ff;
   logic                         found_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   // Cosine result, kept apart while the multiplier forms the sine product
   logic signed [psps_pkg::DIR_W-1:0] dy_hold_ff;

   // Output register
   logic                         rsp_valid_ff;
   logic [psps_pkg::POS_W-1:0]   out_px_ff, out_py_ff, out_pz_ff;
   logic [psps_pkg::DIR_W-1:0]   out_dx_ff, out_dy_ff, out_dz_ff;
   logic [psps_pkg::GROUP_W-1:0] out_grp_ff;

   logic                         req_fire;
   logic                         out_free;
   logic [GN_W-1:0]              n_groups;
   logic [psps_pkg::FRAC_W-1:0]  mu_in;
   logic [psps_pkg::FRAC_W-1:0]  quad_sum;
   logic [CW-1:0]                vsq_in;
   logic [psps_pkg::DIR_W-2:0]   smag;
   logic [CW-1:0]                rem_in, root_in;
   logic signed [CW-1:0]         x_in, y_in, z_in;
   logic [SUM_W-1:0]             sum_in;
   logic [psps_pkg::GROUP_W-1:0] grp_in;
   logic                         found_in;
   logic signed [CW:0]           cos_val, sin_val, mul_op;
   logic signed [PROD_W-1:0]     prod_in;
   logic signed [psps_pkg::DIR_W-1:0] prod_sat;

   function automatic logic signed [psps_pkg::DIR_W-1:0] round_sat(
         input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      r = (p + (PROD_W'(1) <<< 29)) >>> 30;
      if (r > PROD_W'(32767))
         return 16'sh7FFF;
      else if (r < -PROD_W'(32768))
         return 16'sh8000;
      else
         return r[psps_pkg::DIR_W-1:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Clamp the configured group count to the hardware limit
   always_comb begin
      if (int'(gcount_ff) > MAX_GROUPS)
         n_groups = GN_W'(MAX_GROUPS);
      else
         n_groups = GN_W'(gcount_ff);
   end

   // Request decode: mu = 2u - 1 is the fraction with its top bit flipped
   assign mu_in    = req_tdata[31:16] ^ 16'h8000;
   // Quadrant is the top two bits of the angle advanced by one eighth turn
   assign quad_sum = phi_ff + 16'h2000;
   assign vsq_in   = 32'h4000_0000 - 32'(mu_ff * mu_ff);
   // Root of 2^30 - mu^2 reaches 32768 only at mu = 0; hold it at 32767
   assign smag     = (root_ff > 32'd32767) ? 15'h7FFF : root_ff[psps_pkg::DIR_W-2:0];

   // One step of each shared unit, indexed by the step counter
   always_comb begin
      logic [CW-1:0]        bit_v;
      logic [CW-1:0]        trial;
      logic signed [CW-1:0] dx, dy;
      logic [CW-1:0]        at;
      logic [SUM_W-1:0]     p_ext;
      bit_v = 32'h4000_0000 >> {cnt_ff, 1'b0};
      trial = root_ff + bit_v;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (int'(cnt_ff) < psps_pkg::SQRT_STEPS) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_v;
         end else begin
            root_in = root_ff >> 1;
         end
      end

      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      at = psps_pkg::atan_turns(psps_pkg::ATAN_IDX_W'(cnt_ff));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (int'(cnt_ff) < CORDIC_STEPS) begin
         if (!z_ff[CW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - $signed(at);
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + $signed(at);
         end
      end

      // Groups past the probability registers carry zero probability
      if (int'(cnt_ff) < psps_pkg::PROB_REGS)
         p_ext = SUM_W'(prob_ff[cnt_ff[1:0]]);
      else
         p_ext = '0;
      sum_in   = sum_ff;
      grp_in   = grp_ff;
      found_in = found_ff;
      if (!found_ff && (int'(cnt_ff) < int'(n_groups))) begin
         sum_in = sum_ff + p_ext;
         if (sum_in > SUM_W'(gfrac_ff)) begin
            found_in = 1'b1;
            grp_in   = psps_pkg::GROUP_W'(int'(cnt_ff) + 1);
         end
      end
   end

   // Turn the result for the folded residual angle by the stored number of quarter turns
   always_comb begin
      case (quad_ff)
         2'd0: begin
            cos_val = (CW+1)'(x_ff);
            sin_val = (CW+1)'(y_ff);
         end
         2'd1: begin
            cos_val = -(CW+1)'(y_ff);
            sin_val = (CW+1)'(x_ff);
         end
         2'd2: begin
            cos_val = -(CW+1)'(x_ff);
            sin_val = -(CW+1)'(y_ff);
         end
         default: begin
            cos_val = (CW+1)'(y_ff);
            sin_val = -(CW+1)'(x_ff);
         end
      endcase
      mul_op  = (state_ff == ST_MUL_C) ? cos_val : sin_val;
      prod_in = $signed({1'b0, smag}) * mul_op;
   end

   assign prod_sat = round_sat(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gcount_ff    <= 3'd1;
         prob_ff[0]   <= 16'hFFFF;
         prob_ff[1]   <= '0;
         prob_ff[2]   <= '0;
         prob_ff[3]   <= '0;
         src_x_ff     <= '0;
         src_y_ff     <= '0;
         src_z_ff     <= '0;
         cnt_ff       <= '0;
      end else begin
         // Configuration writes; writes must happen only while no request is in flight (the block does not enforce it)
         if (csr_we) begin
            case (csr_index)
               psps_pkg::REG_GROUP_COUNT: gcount_ff  <= csr_wdata[psps_pkg::GROUP_W-1:0];
               psps_pkg::REG_PROB_0:      prob_ff[0] <= csr_wdata[psps_pkg::PROB_W-1:0];
               psps_pkg::REG_PROB_1:      prob_ff[1] <= csr_wdata[psps_pkg::PROB_W-1:0];
               psps_pkg::REG_PROB_2:      prob_ff[2] <= csr_wdata[psps_pkg::PROB_W-1:0];
               psps_pkg::REG_PROB_3:      prob_ff[3] <= csr_wdata[psps_pkg::PROB_W-1:0];
               psps_pkg::REG_SOURCE_X:    src_x_ff   <= csr_wdata;
               psps_pkg::REG_SOURCE_Y:    src_y_ff   <= csr_wdata;
               psps_pkg::REG_SOURCE_Z:    src_z_ff   <= csr_wdata;
               default: ;
            endcase
         end

         // Drop the response once the downstream side takes it, unless the
         // finish step lands a new one on the same edge
         if (rsp_valid_ff && rsp_tready && state_ff != ST_FINISH)
            rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  gfrac_ff <= req_tdata[15:0];
                  mu_ff    <= $signed(mu_in);
                  phi_ff   <= req_tdata[47:32];
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               // Square mu, seed the root, the rotation and the group search
               rem_ff   <= vsq_in;
               root_ff  <= '0;
               x_ff     <= $signed(psps_pkg::CORDIC_GAIN_INV);
               y_ff     <= '0;
               z_ff     <= $signed({phi_ff - {quad_sum[15:14], 14'd0}, 16'd0});
               quad_ff  <= quad_sum[15:14];
               sum_ff   <= '0;
               grp_ff   <= psps_pkg::GROUP_W'(1);
               found_ff <= (int'(n_groups) < 2);
               cnt_ff   <= '0;
               state_ff <= ST_ITER;
            end
            ST_ITER: begin
               rem_ff   <= rem_in;
               root_ff  <= root_in;
               x_ff     <= x_in;
               y_ff     <= y_in;
               z_ff     <= z_in;
               sum_ff   <= sum_in;
               grp_ff   <= grp_in;
               found_ff <= found_in;
               if (int'(cnt_ff) == N_ITER - 1) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_MUL_C;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_MUL_C: begin
               // The multiplier is shared: cosine product first
               prod_ff  <= prod_in;
               state_ff <= ST_MUL_S;
            end
            ST_MUL_S: begin
               // Round the cosine product aside, then form the sine product
               dy_hold_ff <= prod_sat;
               prod_ff    <= prod_in;
               state_ff   <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  out_px_ff    <= src_x_ff;
                  out_py_ff    <= src_y_ff;
                  out_pz_ff    <= src_z_ff;
                  out_dx_ff    <= mu_ff;
                  out_dy_ff    <= dy_hold_ff;
                  out_dz_ff    <= prod_sat;
                  out_grp_ff   <= grp_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, out_grp_ff, out_dz_ff, out_dy_ff, out_dx_ff,
                        out_pz_ff, out_py_ff, out_px_ff};

`ifndef SYNTHESIS
   // An accepted request always starts the load step next
   a_accept_to_load: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_LOAD))
      else $error("request accepted without entering load");

   // A new response appears only from the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside finish");

   // Finish never overwrites a response that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_FINISH))
      else $error("pending response overwritten");
`endif

endmodule

>>> tb/point_source_particle_sampler_tb.sv
`timescale 1ns / 1ps

module point_source_particle_sampler_tb;

   localparam int GROUPS_MAX     = psps_pkg::MAX_GROUPS_DEF;
   localparam int STEPS          = psps_pkg::CORDIC_STEPS_DEF;
   localparam int DRAIN_CYCLES   = 30;
   localparam int WATCHDOG_LIMIT = 2000;  // covers the long hold-off plus one slow particle
   localparam int HOLDOFF_CYCLES = 400;
   localparam int HOLDOFF_AFTER  = 370;   // lands in the middle of a random phase
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 141;
   localparam int MAX_REPORTS    = 10;
   localparam longint HALF_Q30   = 64'sd536870912;
   localparam longint ONE_Q30    = 64'sd1073741824;

   // One request: three uniform fractions
   typedef struct {
      logic [psps_pkg::FRAC_W-1:0] group_rand;
      logic [psps_pkg::FRAC_W-1:0] mu_rand;
      logic [psps_pkg::FRAC_W-1:0] phi_rand;
   } draw_type;

   // One sampled particle as carried on the response bus
   typedef struct {
      logic [psps_pkg::POS_W-1:0]   pos_x;
      logic [psps_pkg::POS_W-1:0]   pos_y;
      logic [psps_pkg::POS_W-1:0]   pos_z;
      logic [psps_pkg::DIR_W-1:0]   dir_x;
      logic [psps_pkg::DIR_W-1:0]   dir_y;
      logic [psps_pkg::DIR_W-1:0]   dir_z;
      logic [psps_pkg::GROUP_W-1:0] energy_group;
   } particle_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // fields from bit 0 up: group_rand[15:0], mu_rand[15:0], phi_rand[15:0]
   logic [psps_pkg::REQ_DAT_W-1:0] req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // fields from bit 0 up: pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, energy_group, pad
   logic [psps_pkg::RSP_DAT_W-1:0] rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [psps_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [psps_pkg::CSR_DAT_W-1:0] csr_wdata  = '0;

   // Shadow of the block's registers, updated as each write goes out
   logic [psps_pkg::GROUP_W-1:0] cfg_group_count = 3'd1;
   logic [psps_pkg::PROB_W-1:0]  cfg_prob [psps_pkg::PROB_REGS] =
      '{16'hFFFF, 16'h0, 16'h0, 16'h0};
   logic [psps_pkg::POS_W-1:0]   cfg_src_x = '0;
   logic [psps_pkg::POS_W-1:0]   cfg_src_y = '0;
   logic [psps_pkg::POS_W-1:0]   cfg_src_z = '0;

   // atan(2^-i) in 2^-32 turn
   longint atan_step [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   draw_type     draw_q [$];       // requests waiting for the driver
   particle_type particle_q [$];   // particles owed by the block, oldest first

   int  sent_total     = 0;     // requests handed to the driver
   int  req_taken      = 0;     // requests accepted by the block
   int  checked_total  = 0;     // responses accepted and checked
   int  mismatch_count = 0;
   int  req_gap        = 0;
   int  rsp_stall      = 0;
   int  idle_cycles    = 0;
   bit  req_quiet      = 1'b0;  // no gaps between requests
   bit  rsp_quiet      = 1'b0;  // no stalls on the response side
   bit  hold_rsp       = 1'b0;  // long receiver hold-off

   point_source_particle_sampler #(
      .MAX_GROUPS   (GROUPS_MAX),
      .CORDIC_STEPS (STEPS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial forever #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Particle prediction
   // ---------------------------------------------------------------

   // Bitwise integer square root, floor
   function automatic logic [31:0] int_sqrt(logic [31:0] v);
      logic [31:0] rem, root, place;
      rem   = v;
      root  = '0;
      place = 32'h4000_0000;
      while (place > rem) place >>= 2;
      while (place != 0) begin
         if (rem >= root + place) begin
            rem  -= root + place;
            root  = (root >> 1) + place;
         end else begin
            root >>= 1;
         end
         place >>= 2;
      end
      return root;
   endfunction

   function automatic logic [psps_pkg::DIR_W-1:0] clamp_q15(longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[psps_pkg::DIR_W-1:0];
   endfunction

   // Cosine and sine in Q2.30 of an angle given in 2^-32 turn.
   // Fold to the nearest quarter turn, rotate the residual, then unfold.
   function automatic void rotate_turn(input logic [31:0] angle,
                                       output longint cs, output longint sn);
      logic [31:0] quad, resid;
      longint      x, y, z, dx, dy;
      int          i;
      quad  = ((angle + 32'h2000_0000) >> 30) & 32'd3;
      resid = angle - (quad << 30);
      z     = longint'($signed(resid));
      x     = longint'(psps_pkg::CORDIC_GAIN_INV);
      y     = 0;
      for (i = 0; i < STEPS && i < 24; i++) begin
         // arithmetic shift of a signed value floors
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= atan_step[i];
         end else begin
            x += dx;
            y -= dy;
            z += atan_step[i];
         end
      end
      case (quad)
         32'd0:   begin cs = x;  sn = y;  end
         32'd1:   begin cs = -y; sn = x;  end
         32'd2:   begin cs = -x; sn = -y; end
         default: begin cs = y;  sn = -x; end
      endcase
   endfunction

   // Inverse cumulative pick: first group whose running sum exceeds the fraction, else group one
   function automatic logic [psps_pkg::GROUP_W-1:0] energy_group_of(
         logic [psps_pkg::FRAC_W-1:0] frac);
      int          n, k;
      logic [31:0] run_sum;
      n = cfg_group_count;
      if (n > GROUPS_MAX) n = GROUPS_MAX;
      if (n < 2) return 3'd1;
      run_sum = '0;
      for (k = 0; k < n; k++) begin
         run_sum += (k < psps_pkg::PROB_REGS) ? cfg_prob[k] : 16'd0;
         if (run_sum > frac) return 3'(k + 1);
      end
      return 3'd1;
   endfunction

   function automatic particle_type sample_particle(logic [psps_pkg::REQ_DAT_W-1:0] req);
      logic [psps_pkg::FRAC_W-1:0] g_frac, mu_frac, phi_frac;
      logic [31:0]                 smag;
      longint                      mu, cs, sn;
      particle_type                p;
      g_frac   = req[15:0];
      mu_frac  = req[31:16];
      phi_frac = req[47:32];
      mu       = longint'(mu_frac) - 32768;
      smag     = int_sqrt(32'(ONE_Q30 - mu * mu));
      if (smag > 32767) smag = 32767;
      rotate_turn({phi_frac, 16'h0000}, cs, sn);
      p.pos_x        = cfg_src_x;
      p.pos_y        = cfg_src_y;
      p.pos_z        = cfg_src_z;
      p.dir_x        = mu[psps_pkg::DIR_W-1:0];
      p.dir_y        = clamp_q15((longint'(smag) * cs + HALF_Q30) >>> 30);
      p.dir_z        = clamp_q15((longint'(smag) * sn + HALF_Q30) >>> 30);
      p.energy_group = energy_group_of(g_frac);
      return p;
   endfunction

   // ---------------------------------------------------------------
   // Request driver: feed draw_q onto the request bus with random gaps
   // ---------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      draw_type d;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap     = 0;
      end else begin
         // predict at acceptance; the register shadow is stable while traffic runs
         if (req_tvalid && req_tready) begin
            particle_q.push_back(sample_particle(req_tdata));
            req_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0 || draw_q.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_tvalid <= 1'b0;
            end else begin
               d = draw_q.pop_front();
               req_tdata  <= {d.phi_rand, d.mu_rand, d.group_rand};
               req_tvalid <= 1'b1;
               req_gap     = req_quiet ? 0 : $urandom_range(0, 8);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor: accept with random stalls unless rsp_quiet is set, check field by field
   // ---------------------------------------------------------------
   task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("particle %0d %s: expected %h, got %h", checked_total, field, want, got);
   endtask

   always @(posedge clock) begin : rsp_monitor
      particle_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.pos_x        = rsp_tdata[31:0];
            got.pos_y        = rsp_tdata[63:32];
            got.pos_z        = rsp_tdata[95:64];
            got.dir_x        = rsp_tdata[111:96];
            got.dir_y        = rsp_tdata[127:112];
            got.dir_z        = rsp_tdata[143:128];
            got.energy_group = rsp_tdata[146:144];
            if (particle_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("particle %0d: response with nothing owed, data %h",
                           checked_total, rsp_tdata);
            end else begin
               want = particle_q.pop_front();
               if (got.pos_x !== want.pos_x) note_mismatch("pos_x", want.pos_x, got.pos_x);
               if (got.pos_y !== want.pos_y) note_mismatch("pos_y", want.pos_y, got.pos_y);
               if (got.pos_z !== want.pos_z) note_mismatch("pos_z", want.pos_z, got.pos_z);
               if (got.dir_x !== want.dir_x) note_mismatch("dir_x", want.dir_x, got.dir_x);
               if (got.dir_y !== want.dir_y) note_mismatch("dir_y", want.dir_y, got.dir_y);
               if (got.dir_z !== want.dir_z) note_mismatch("dir_z", want.dir_z, got.dir_z);
               if (got.energy_group !== want.energy_group)
                  note_mismatch("energy_group", want.energy_group, got.energy_group);
            end
            checked_total++;
            rsp_stall = rsp_quiet ? 0 : $urandom_range(0, 8);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= !hold_rsp && rsp_stall == 0;
      end
   end

   // Hold the receiver off for a long stretch mid-run so the block backs up
   // and stalls its input while the driver keeps offering requests.
   initial begin : rsp_holdoff
      do @(posedge clock); while (req_taken < HOLDOFF_AFTER);
      hold_rsp <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Count busy cycles without any transaction; give up at the limit
   always @(posedge clock) begin : watchdog
      if (reset || sent_total == checked_total ||
          (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("point_source_particle_sampler: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------

   // Drive one register write; it lands at the next edge. Leave csr_we high
   // so back-to-back writes follow without a gap; close_writes drops it.
   task automatic write_reg(logic [psps_pkg::CSR_IDX_W-1:0] idx,
                            logic [psps_pkg::CSR_DAT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         psps_pkg::REG_GROUP_COUNT: cfg_group_count = value[psps_pkg::GROUP_W-1:0];
         psps_pkg::REG_PROB_0:      cfg_prob[0]     = value[psps_pkg::PROB_W-1:0];
         psps_pkg::REG_PROB_1:      cfg_prob[1]     = value[psps_pkg::PROB_W-1:0];
         psps_pkg::REG_PROB_2:      cfg_prob[2]     = value[psps_pkg::PROB_W-1:0];
         psps_pkg::REG_PROB_3:      cfg_prob[3]     = value[psps_pkg::PROB_W-1:0];
         psps_pkg::REG_SOURCE_X:    cfg_src_x       = value;
         psps_pkg::REG_SOURCE_Y:    cfg_src_y       = value;
         psps_pkg::REG_SOURCE_Z:    cfg_src_z       = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic close_writes();
      csr_we <= 1'b0;
   endtask

   task automatic push_draw(logic [psps_pkg::FRAC_W-1:0] g, logic [psps_pkg::FRAC_W-1:0] mu,
                            logic [psps_pkg::FRAC_W-1:0] phi);
      draw_type d;
      d.group_rand = g;
      d.mu_rand    = mu;
      d.phi_rand   = phi;
      draw_q.push_back(d);
      sent_total++;
   endtask

   // Wait until every owed particle has come back, then let the pipe drain
   task automatic settle();
      while (checked_total != sent_total) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(int n_items);
      logic [psps_pkg::FRAC_W-1:0] cum [psps_pkg::PROB_REGS];
      logic [psps_pkg::FRAC_W-1:0] g, mu, phi;
      logic [31:0]                 src;
      int                          style, k, n;
      longint                      acc;
      // random register setting, group counts past the limit included
      write_reg(psps_pkg::REG_GROUP_COUNT, 32'($urandom_range(0, 7)));
      style = $urandom_range(0, 2);
      for (k = 0; k < psps_pkg::PROB_REGS; k++) begin
         case (style)
            0:       write_reg(psps_pkg::REG_PROB_0 + 3'(k), 32'($urandom_range(0, 65535)));
            1:       write_reg(psps_pkg::REG_PROB_0 + 3'(k), 32'($urandom_range(0, 21845)));
            default: write_reg(psps_pkg::REG_PROB_0 + 3'(k),
                               $urandom_range(0, 1) ? 32'hFFFF : 32'h0);
         endcase
      end
      for (k = 0; k < 3; k++) begin
         case ($urandom_range(0, 5))
            0:       src = 32'h7FFF_FFFF;
            1:       src = 32'h8000_0000;
            default: src = $urandom;
         endcase
         write_reg(psps_pkg::REG_SOURCE_X + 3'(k), src);
      end
      close_writes();

      // running sums, to aim some group fractions at the boundaries
      acc = 0;
      for (k = 0; k < psps_pkg::PROB_REGS; k++) begin
         acc   += cfg_prob[k];
         cum[k] = (acc > 65535) ? 16'hFFFF : acc[psps_pkg::FRAC_W-1:0];
      end

      for (n = 0; n < n_items; n++) begin
         if ($urandom_range(0, 3) == 0)
            g = 16'(int'(cum[$urandom_range(0, 3)]) - int'($urandom_range(0, 1)));
         else
            g = 16'($urandom_range(0, 65535));
         case ($urandom_range(0, 7))
            0:       mu = 16'($urandom_range(0, 3));
            1:       mu = 16'(32766 + $urandom_range(0, 4));
            2:       mu = 16'(65532 + $urandom_range(0, 3));
            default: mu = 16'($urandom_range(0, 65535));
         endcase
         // quadrant boundaries sit at multiples of an eighth turn
         if ($urandom_range(0, 5) == 0)
            phi = 16'(8192 * $urandom_range(0, 7) + $urandom_range(0, 2) - 1);
         else
            phi = 16'($urandom_range(0, 65535));
         push_draw(g, mu, phi);
      end
      settle();
   endtask

   initial begin : stimulus
      int p;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: one group. Direction extremes: mu at both poles, the equator
      // where the root saturates, the four axes and three of the four quadrant boundaries.
      push_draw(16'h0000, 16'h0000, 16'h0000);
      push_draw(16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_draw(16'h0000, 16'h8000, 16'h0000);
      push_draw(16'h0000, 16'h8000, 16'h4000);
      push_draw(16'h0000, 16'h8000, 16'h8000);
      push_draw(16'h0000, 16'h8000, 16'hC000);
      push_draw(16'h0000, 16'h8000, 16'h2000);
      push_draw(16'h0000, 16'h8000, 16'h1FFF);
      push_draw(16'h0000, 16'h8001, 16'h6000);
      push_draw(16'h0000, 16'h0001, 16'h9C40);
      push_draw(16'hFFFF, 16'h7FFF, 16'hE000);
      settle();

      // Four near-equal groups, source point at the coordinate extremes;
      // step the group fraction across each running-sum boundary.
      write_reg(psps_pkg::REG_GROUP_COUNT, 32'd4);
      write_reg(psps_pkg::REG_PROB_0, 32'd16384);
      write_reg(psps_pkg::REG_PROB_1, 32'd16384);
      write_reg(psps_pkg::REG_PROB_2, 32'd16384);
      write_reg(psps_pkg::REG_PROB_3, 32'd16383);
      write_reg(psps_pkg::REG_SOURCE_X, 32'h7FFF_FFFF);
      write_reg(psps_pkg::REG_SOURCE_Y, 32'h8000_0000);
      write_reg(psps_pkg::REG_SOURCE_Z, 32'hFFFF_FFFF);
      close_writes();
      push_draw(16'd16383, 16'h1234, 16'h0100);
      push_draw(16'd16384, 16'hEDCB, 16'h3F00);
      push_draw(16'd32767, 16'h4000, 16'h5000);
      push_draw(16'd32768, 16'hC000, 16'h7000);
      push_draw(16'd49151, 16'h2000, 16'hA000);
      push_draw(16'd49152, 16'hE000, 16'hB000);
      push_draw(16'd65534, 16'h0800, 16'hD000);
      push_draw(16'd65535, 16'hF800, 16'hF000);
      settle();

      // Two full groups: the second is reached only at the top fraction
      write_reg(psps_pkg::REG_GROUP_COUNT, 32'd2);
      write_reg(psps_pkg::REG_PROB_1, 32'hFFFF);
      write_reg(psps_pkg::REG_PROB_0, 32'hFFFF);
      close_writes();
      push_draw(16'd65534, 16'h8000, 16'h0000);
      push_draw(16'd65535, 16'h8000, 16'h0000);
      settle();

      // Count past the limit saturates; all-zero probabilities never
      // exceed the fraction, so group one comes back
      write_reg(psps_pkg::REG_GROUP_COUNT, 32'd7);
      write_reg(psps_pkg::REG_PROB_0, 32'h0);
      write_reg(psps_pkg::REG_PROB_1, 32'h0);
      write_reg(psps_pkg::REG_PROB_2, 32'h0);
      write_reg(psps_pkg::REG_PROB_3, 32'h0);
      close_writes();
      push_draw(16'h0000, 16'h3000, 16'h1000);
      push_draw(16'hFFFF, 16'hD000, 16'h9000);
      settle();

      // Random phases: the first runs back to back, the second idles only the response side,
      // the fourth only the request side, and the others idle both at random
      for (p = 0; p < RANDOM_PHASES; p++) begin
         req_quiet = (p == 0 || p == 1);
         rsp_quiet = (p == 0 || p == 3);
         run_random_phase(PHASE_ITEMS);
      end

      if (mismatch_count == 0 && particle_q.size() == 0) begin
         $display("point_source_particle_sampler: match");
      end else begin
         $display("point_source_particle_sampler: mismatch");
      end
      $finish;
   end

endmodule
